@@ rtl/bcq_pkg.sv @@
// Shared types and constants for the blocked byte queue.
// No dependencies; used by bcq_ctrl, bcq_store and blocked_char_queue.
`timescale 1ns / 1ps
`default_nettype none

package bcq_pkg;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_GET   = 2'd1,
        OP_UNPUT = 2'd2,
        OP_FLUSH = 2'd3
    } t_op;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RETRY = 1'b1;

    localparam int ROOM_W = 9;

    // Access request from the pointer logic to the byte store.
    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_cmd;

endpackage

`default_nettype wire

@@ rtl/bcq_store.sv @@
// Byte store of the blocked queue: one write/read port, registered read data.
// Depends on bcq_pkg for the access request type.
`timescale 1ns / 1ps
`default_nettype none

module bcq_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic              i_clk,
    input  wire bcq_pkg::t_mem_cmd i_cmd,
    input  wire logic [AW-1:0]     i_addr,
    input  wire logic [7:0]        i_wdata,
    output logic      [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/bcq_ctrl.sv @@
// Pointer and block bookkeeping of the blocked queue; issues store accesses.
// Depends on bcq_pkg for opcodes, status codes and the access request type.
`timescale 1ns / 1ps
`default_nettype none

module bcq_ctrl #(
    parameter int NUM_BLOCKS  = 8,
    parameter int BLOCK_BYTES = 32,
    parameter int AW          = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [1:0]                   i_opcode,
    output bcq_pkg::t_mem_cmd                 o_cmd,
    output logic      [AW-1:0]                o_addr,
    output logic                              o_valid,
    output logic                              o_rd_flag,
    output logic                              o_status,
    output logic      [bcq_pkg::ROOM_W-1:0]   o_room
);

    localparam int STORE = NUM_BLOCKS * BLOCK_BYTES;
    localparam int BW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int UW    = $clog2(NUM_BLOCKS + 1);
    localparam int SW    = UW + 1;
    localparam int OW    = $clog2(BLOCK_BYTES + 1);
    localparam int HW    = $clog2(STORE + 1);
    localparam int RW    = (HW > bcq_pkg::ROOM_W) ? HW : bcq_pkg::ROOM_W;

    logic [BW-1:0] r_head, n_head;
    logic [UW-1:0] r_used, n_used;
    logic [OW-1:0] r_hstart, n_hstart;
    logic [OW-1:0] r_tend, n_tend;
    logic [HW-1:0] r_held, n_held;
    logic          r_valid, r_rd_flag, r_status;
    logic [bcq_pkg::ROOM_W-1:0] r_room;

    logic          n_status;
    logic [SW-1:0] sum_next, sum_cur;
    logic [BW-1:0] tail_next, tail_cur, head_inc;
    logic [OW-1:0] blk_end, blk_start;
    logic [BW-1:0] acc_blk;
    logic [OW-1:0] acc_off;
    logic [RW-1:0] room_full;
    logic          accept;
    bcq_pkg::t_mem_cmd cmd;

    assign accept = i_start;

    // Ring positions of the tail, a new tail block and the next head; byte bounds.
    always_comb begin
        sum_next  = SW'(r_head) + SW'(r_used);
        sum_cur   = sum_next - SW'(1);
        tail_next = (sum_next >= SW'(NUM_BLOCKS)) ? BW'(sum_next - SW'(NUM_BLOCKS))
                                                  : BW'(sum_next);
        tail_cur  = (sum_cur >= SW'(NUM_BLOCKS)) ? BW'(sum_cur - SW'(NUM_BLOCKS))
                                                 : BW'(sum_cur);
        head_inc  = (r_head == BW'(NUM_BLOCKS - 1)) ? '0 : r_head + BW'(1);
        blk_end   = (r_used == UW'(1)) ? r_tend : OW'(BLOCK_BYTES);
        blk_start = (r_used == UW'(1)) ? r_hstart : '0;
    end

    always_comb begin
        n_head   = r_head;
        n_used   = r_used;
        n_hstart = r_hstart;
        n_tend   = r_tend;
        n_held   = r_held;
        n_status = bcq_pkg::STATUS_OK;
        cmd      = '0;
        acc_blk  = tail_cur;
        acc_off  = r_tend;
        if (accept) begin
            case (bcq_pkg::t_op'(i_opcode))
                bcq_pkg::OP_PUT: begin
                    if (r_used == '0) begin
                        n_used   = UW'(1);
                        n_hstart = '0;
                        acc_blk  = r_head;
                        acc_off  = '0;
                        cmd.wr   = 1'b1;
                    end else if (r_tend >= OW'(BLOCK_BYTES)) begin
                        if (r_used >= UW'(NUM_BLOCKS)) begin
                            n_status = bcq_pkg::STATUS_RETRY;
                        end else begin
                            n_used  = r_used + UW'(1);
                            acc_blk = tail_next;
                            acc_off = '0;
                            cmd.wr  = 1'b1;
                        end
                    end else begin
                        cmd.wr = 1'b1;
                    end
                    if (cmd.wr) begin
                        n_tend = acc_off + OW'(1);
                        n_held = r_held + HW'(1);
                    end
                end
                bcq_pkg::OP_GET: begin
                    if (r_used != '0) begin
                        acc_blk = r_head;
                        acc_off = r_hstart;
                        if (r_hstart < blk_end) begin
                            cmd.rd   = 1'b1;
                            n_hstart = r_hstart + OW'(1);
                            n_held   = r_held - HW'(1);
                        end
                        // Release the head block once drained.
                        if (n_hstart >= blk_end) begin
                            if (r_used == UW'(1)) begin
                                n_head   = '0;
                                n_used   = '0;
                                n_hstart = '0;
                                n_tend   = '0;
                                n_held   = '0;
                            end else begin
                                n_head   = head_inc;
                                n_used   = r_used - UW'(1);
                                n_hstart = '0;
                            end
                        end
                    end
                end
                bcq_pkg::OP_UNPUT: begin
                    if (r_used != '0) begin
                        acc_blk = tail_cur;
                        acc_off = r_tend - OW'(1);
                        if (r_tend > blk_start) begin
                            cmd.rd = 1'b1;
                            n_tend = r_tend - OW'(1);
                            n_held = r_held - HW'(1);
                        end
                        // Release the tail block once drained; the previous one is full.
                        if (n_tend <= blk_start) begin
                            if (r_used == UW'(1)) begin
                                n_head   = '0;
                                n_used   = '0;
                                n_hstart = '0;
                                n_tend   = '0;
                                n_held   = '0;
                            end else begin
                                n_used = r_used - UW'(1);
                                n_tend = OW'(BLOCK_BYTES);
                            end
                        end
                    end
                end
                default: begin
                    n_head   = '0;
                    n_used   = '0;
                    n_hstart = '0;
                    n_tend   = '0;
                    n_held   = '0;
                end
            endcase
        end
        room_full = RW'(STORE) - RW'(n_held);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_used    <= '0;
            r_hstart  <= '0;
            r_tend    <= '0;
            r_held    <= '0;
            r_valid   <= 1'b0;
            r_rd_flag <= 1'b0;
            r_status  <= bcq_pkg::STATUS_OK;
            r_room    <= '0;
        end else begin
            r_head    <= n_head;
            r_used    <= n_used;
            r_hstart  <= n_hstart;
            r_tend    <= n_tend;
            r_held    <= n_held;
            r_valid   <= accept;
            r_rd_flag <= cmd.rd;
            r_status  <= n_status;
            r_room    <= room_full[bcq_pkg::ROOM_W-1:0];
        end
    end

    assign o_cmd     = cmd;
    assign o_addr    = AW'(acc_blk) * AW'(BLOCK_BYTES) + AW'(acc_off);
    assign o_valid   = r_valid;
    assign o_rd_flag = r_rd_flag;
    assign o_status  = r_status;
    assign o_room    = r_room;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HW'(STORE))
        else $error("bytes held exceed store size");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used == '0) |-> (r_held == '0 && r_head == '0 && r_tend == '0))
        else $error("empty queue with stale pointers");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(NUM_BLOCKS))
        else $error("blocks in use exceed ring size");

    a_retry_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == bcq_pkg::STATUS_RETRY) |-> (r_used == UW'(NUM_BLOCKS)))
        else $error("put refused while a block was free");

    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.wr && cmd.rd))
        else $error("store read and written in one cycle");

endmodule

`default_nettype wire

@@ rtl/blocked_char_queue.sv @@
// Latency: a result strobes on o_valid in the cycle after its request is taken.
// Throughput: one request per cycle; the single store port serves the at most one
// byte access that each operation needs, so o_busy stays low.
// Reset (synchronous, active low) empties the queue; store contents are left
// undefined and need no clearing pass, as only written bytes are ever read.
// Depends on bcq_pkg, bcq_ctrl and bcq_store.
`timescale 1ns / 1ps
`default_nettype none

module blocked_char_queue #(
    parameter int NUM_BLOCKS  = 8,
    parameter int BLOCK_BYTES = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [1:0]                 i_opcode,
    input  wire logic [7:0]                 i_put_byte,
    output logic                            o_busy,
    output logic                            o_valid,
    output logic      [7:0]                 o_byte_out,
    output logic                            o_status,
    output logic      [bcq_pkg::ROOM_W-1:0] o_room
);

    localparam int STORE = NUM_BLOCKS * BLOCK_BYTES;
    localparam int AW    = $clog2(STORE);

    bcq_pkg::t_mem_cmd cmd;
    logic [AW-1:0]     addr;
    logic [7:0]        rdata;
    logic              rd_flag;

    bcq_ctrl #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .AW          (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_opcode  (i_opcode),
        .o_cmd     (cmd),
        .o_addr    (addr),
        .o_valid   (o_valid),
        .o_rd_flag (rd_flag),
        .o_status  (o_status),
        .o_room    (o_room)
    );

    bcq_store #(
        .DEPTH (STORE),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .i_addr  (addr),
        .i_wdata (i_put_byte),
        .o_rdata (rdata)
    );

    // Drop the stale read data when the request removed no byte.
    assign o_byte_out = rd_flag ? rdata : 8'd0;
    assign o_busy     = 1'b0;

endmodule

`default_nettype wire
